### sv/mipd_pkg.sv
// ----------------------------------------------------------------------------
// mipd_pkg
// Shared types and constants for the minimum-image pair distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package mipd_pkg;

   localparam int MAX_PART     = 64;
   localparam int IDX_W        = $clog2(MAX_PART);
   localparam int CNT_W        = IDX_W + 1;
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;
   localparam int SQ_STAGES    = 8;
   localparam int SQ_STEPS     = 4;

   localparam logic CMD_MOVE    = 1'b0;
   localparam logic CMD_RESTORE = 1'b1;

   localparam logic [2:0] CSR_ACTIVE = 3'd0;
   localparam logic [2:0] CSR_BOX_X  = 3'd1;
   localparam logic [2:0] CSR_BOX_Y  = 3'd2;
   localparam logic [2:0] CSR_BOX_Z  = 3'd3;
   localparam logic [2:0] CSR_INV_X  = 3'd4;
   localparam logic [2:0] CSR_INV_Y  = 3'd5;
   localparam logic [2:0] CSR_INV_Z  = 3'd6;

   typedef logic [2:0][31:0] vec_type;

   typedef struct packed {
      logic [IDX_W-1:0] who;
      logic [IDX_W-1:0] partner;
      logic             last;
      vec_type          pos_who;
      vec_type          pos_p;
   } pair_type;

   typedef struct packed {
      logic [IDX_W-1:0] who;
      logic [IDX_W-1:0] partner;
      logic             last;
   } meta_type;

   typedef struct packed {
      logic [2:0][30:0] box;
      logic [2:0][31:0] inv;
   } geom_type;

endpackage

`default_nettype wire

### sv/mipd_fifo.sv
// ----------------------------------------------------------------------------
// mipd_fifo
// Short queue of pair jobs between the front sequencer and the math pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module mipd_fifo (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   input  wire mipd_pkg::pair_type              push_data,
   input  wire logic                            pop,
   output logic                                 head_valid,
   output mipd_pkg::pair_type                   head_data,
   output logic [mipd_pkg::FIFO_CNT_W-1:0]      count
);
   import mipd_pkg::*;

   pair_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                    do_pop;

   assign head_valid = (cnt_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign count      = cnt_ff;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### sv/mipd_front.sv
// ----------------------------------------------------------------------------
// mipd_front
// Accepts move and restore commands, updates the position store and walks
// the partner list, queuing one pair job per partner.
// ----------------------------------------------------------------------------
`default_nettype none

module mipd_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [mipd_pkg::CNT_W-1:0]         active_count,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic                               req_command,
   input  wire logic [mipd_pkg::IDX_W-1:0]         req_particle,
   input  wire mipd_pkg::vec_type                  req_pos,
   output logic                                    push_valid,
   output mipd_pkg::pair_type                      push_data,
   input  wire logic [mipd_pkg::FIFO_CNT_W-1:0]    fifo_cnt
);
   import mipd_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_RUN} state_type;

   state_type          state_ff;
   logic [IDX_W-1:0]   who_ff;
   vec_type            pos_who_ff;
   vec_type            saved_ff;
   logic [IDX_W-1:0]   saved_idx_ff;
   logic [IDX_W-1:0]   p_ff;
   logic               rd_pend_ff;
   logic [IDX_W-1:0]   rd_p_ff;
   logic               rd_last_ff;

   vec_type            mem [MAX_PART];
   logic [MAX_PART-1:0] vld_ff;
   vec_type            rd_data_ff;
   logic               rd_vld_ff;

   logic [CNT_W-1:0]   live;
   logic [IDX_W-1:0]   last_idx;
   logic               accept;
   logic               credit;
   logic               issue;
   logic               step;
   logic               we;
   logic [IDX_W-1:0]   waddr;
   vec_type            wdata;
   logic [IDX_W-1:0]   rd_addr;

   always_comb begin
      live = (active_count > CNT_W'(MAX_PART)) ? CNT_W'(MAX_PART) : active_count;
      // last partner is the top active index unless that is the moved one
      if ({1'b0, who_ff} == live - 1'b1) begin
         last_idx = IDX_W'(live - CNT_W'(2));
      end else begin
         last_idx = IDX_W'(live - 1'b1);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign credit     = ({1'b0, fifo_cnt} + (FIFO_CNT_W+1)'(rd_pend_ff))
                       < (FIFO_CNT_W+1)'(FIFO_DEPTH);
   assign issue      = (state_ff == ST_RUN) && (p_ff != who_ff) && credit;
   assign step       = (state_ff == ST_RUN) && ((p_ff == who_ff) || credit);
   assign rd_addr    = (state_ff == ST_RUN) ? p_ff : req_particle;

   always_comb begin
      we    = 1'b0;
      waddr = saved_idx_ff;
      wdata = saved_ff;
      if (accept && (req_command == CMD_RESTORE)) begin
         we = 1'b1;
      end else if (state_ff == ST_LOAD) begin
         we    = 1'b1;
         waddr = who_ff;
         wdata = pos_who_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         who_ff       <= '0;
         pos_who_ff   <= '0;
         saved_ff     <= '0;
         saved_idx_ff <= '0;
         p_ff         <= '0;
         rd_pend_ff   <= 1'b0;
         rd_p_ff      <= '0;
         rd_last_ff   <= 1'b0;
      end else begin
         rd_pend_ff <= issue;
         rd_p_ff    <= p_ff;
         rd_last_ff <= (p_ff == last_idx);
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  p_ff <= '0;
                  if (req_command == CMD_MOVE) begin
                     if ({1'b0, req_particle} < live) begin
                        who_ff     <= req_particle;
                        pos_who_ff <= req_pos;
                        state_ff   <= ST_LOAD;
                     end
                  end else begin
                     who_ff     <= saved_idx_ff;
                     pos_who_ff <= saved_ff;
                     if (({1'b0, saved_idx_ff} < live) && (live >= CNT_W'(2))) begin
                        state_ff <= ST_RUN;
                     end
                  end
               end
            end
            ST_LOAD: begin
               saved_ff     <= rd_vld_ff ? rd_data_ff : '0;
               saved_idx_ff <= who_ff;
               state_ff     <= (live >= CNT_W'(2)) ? ST_RUN : ST_IDLE;
            end
            ST_RUN: begin
               if (step) begin
                  p_ff <= p_ff + 1'b1;
                  if (p_ff == last_idx) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // entries never written read as the reset origin
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (we) begin
            vld_ff[waddr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   always_comb begin
      push_valid        = rd_pend_ff;
      push_data.who     = who_ff;
      push_data.partner = rd_p_ff;
      push_data.last    = rd_last_ff;
      push_data.pos_who = pos_who_ff;
      push_data.pos_p   = rd_vld_ff ? rd_data_ff : '0;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (fifo_cnt < FIFO_CNT_W'(FIFO_DEPTH)))
      else $error("pair queue overflow");

   a_no_self_pair: assert property (@(posedge clock) disable iff (reset)
      issue |-> (p_ff != who_ff))
      else $error("moved particle paired with itself");

   a_run_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> ({1'b0, p_ff} < live) && ({1'b0, who_ff} < live))
      else $error("partner walk beyond active particles");

endmodule

`default_nettype wire

### sv/mipd_back.sv
// ----------------------------------------------------------------------------
// mipd_back
// Math pipe: minimum-image wrap per axis, squared distance and a pipelined
// integer square root, one pair record per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mipd_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mipd_pkg::geom_type         geom,
   input  wire logic                       head_valid,
   input  wire mipd_pkg::pair_type         head_data,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [207:0]                    rsp_tdata,  // moved, partner, disp_x/y/z,
                                                       // dist_sq, dist_res, zero pad
   output logic                            rsp_tlast
);
   import mipd_pkg::*;

   typedef struct packed {
      meta_type     meta;
      vec_type      disp;
      logic [63:0]  v;
      logic [34:0]  rem;
      logic [31:0]  root;
   } sq_type;

   function automatic sq_type sq_step(input sq_type s);
      logic [34:0] r;
      logic [34:0] trial;
      sq_type      o;
      o     = s;
      r     = {s.rem[32:0], s.v[63:62]};
      trial = {1'b0, s.root, 2'b01};
      if (r >= trial) begin
         o.rem  = r - trial;
         o.root = {s.root[30:0], 1'b1};
      end else begin
         o.rem  = r;
         o.root = {s.root[30:0], 1'b0};
      end
      o.v = {s.v[61:0], 2'b00};
      return o;
   endfunction

   logic adv;

   logic              a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff, f_vld_ff;
   meta_type          a_meta_ff, b_meta_ff, c_meta_ff, d_meta_ff, e_meta_ff, f_meta_ff;
   vec_type           a_d_ff, a_d_in;
   logic [2:0][15:0]  b_m1_ff, b_m1_in, b_m2_ff, b_m2_in;
   logic [2:0][15:0]  c_g_ff, c_g_in;
   vec_type           d_disp_ff, d_disp_in, e_disp_ff, f_disp_ff;
   logic [2:0][63:0]  e_sq_ff, e_sq_in;
   logic [63:0]       f_sum_ff, f_sum_in;

   logic [SQ_STAGES-1:0] sq_vld_ff;
   sq_type               sq_ff [SQ_STAGES];
   sq_type               sq_in [SQ_STAGES];

   logic              out_vld_ff;
   meta_type          out_meta_ff;
   vec_type           out_disp_ff;
   logic [63:0]       out_sq_ff;
   logic [31:0]       out_res_ff;

   assign adv = !out_vld_ff || rsp_tready;
   assign pop = adv && head_valid;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic [31:0] lo;
         logic [31:0] hi;
         logic [31:0] p1;
         logic [47:0] p2;
         logic signed [47:0] p3;
         logic signed [63:0] p4;
         // lower index minus higher index
         if (head_data.partner < head_data.who) begin
            lo = head_data.pos_p[a];
            hi = head_data.pos_who[a];
         end else begin
            lo = head_data.pos_who[a];
            hi = head_data.pos_p[a];
         end
         a_d_in[a] = lo - hi;
         // only the fraction of the box count matters for the wrap
         p1 = a_d_ff[a][15:0] * geom.inv[a][31:16];
         p2 = a_d_ff[a] * geom.inv[a][15:0];
         b_m1_in[a] = p1[15:0];
         b_m2_in[a] = p2[31:16];
         c_g_in[a]  = b_m1_ff[a] + b_m2_ff[a];
         p3 = $signed({1'b0, geom.box[a]}) * $signed(c_g_ff[a]);
         d_disp_in[a] = p3[47:16];
         p4 = $signed(d_disp_ff[a]) * $signed(d_disp_ff[a]);
         e_sq_in[a] = p4;
      end
      // each square is at most 2^62, so the sum cannot saturate
      f_sum_in = e_sq_ff[0] + e_sq_ff[1] + e_sq_ff[2];
   end

   always_comb begin
      for (int k = 0; k < SQ_STAGES; k++) begin
         sq_type s;
         if (k == 0) begin
            s.meta = f_meta_ff;
            s.disp = f_disp_ff;
            s.v    = f_sum_ff;
            s.rem  = '0;
            s.root = '0;
         end else begin
            s = sq_ff[k-1];
         end
         for (int j = 0; j < SQ_STEPS; j++) begin
            s = sq_step(s);
         end
         sq_in[k] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         d_vld_ff   <= 1'b0;
         e_vld_ff   <= 1'b0;
         f_vld_ff   <= 1'b0;
         sq_vld_ff  <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff   <= head_valid;
         b_vld_ff   <= a_vld_ff;
         c_vld_ff   <= b_vld_ff;
         d_vld_ff   <= c_vld_ff;
         e_vld_ff   <= d_vld_ff;
         f_vld_ff   <= e_vld_ff;
         sq_vld_ff  <= {sq_vld_ff[SQ_STAGES-2:0], f_vld_ff};
         out_vld_ff <= sq_vld_ff[SQ_STAGES-1];
      end
   end

   // the sqrt stages shift the 64-bit sum out as they go; the output takes only the root
   always_ff @(posedge clock) begin
      if (adv) begin
         a_meta_ff   <= '{who: head_data.who, partner: head_data.partner,
                          last: head_data.last};
         a_d_ff      <= a_d_in;
         b_meta_ff   <= a_meta_ff;
         b_m1_ff     <= b_m1_in;
         b_m2_ff     <= b_m2_in;
         c_meta_ff   <= b_meta_ff;
         c_g_ff      <= c_g_in;
         d_meta_ff   <= c_meta_ff;
         d_disp_ff   <= d_disp_in;
         e_meta_ff   <= d_meta_ff;
         e_disp_ff   <= d_disp_ff;
         e_sq_ff     <= e_sq_in;
         f_meta_ff   <= e_meta_ff;
         f_disp_ff   <= e_disp_ff;
         f_sum_ff    <= f_sum_in;
         for (int k = 0; k < SQ_STAGES; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         out_meta_ff <= sq_ff[SQ_STAGES-1].meta;
         out_disp_ff <= sq_ff[SQ_STAGES-1].disp;
         out_res_ff  <= sq_ff[SQ_STAGES-1].root;
      end
   end

   // keep the sum beside the root stages
   logic [63:0] sum_line_ff [SQ_STAGES];
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_line_ff[0] <= f_sum_ff;
         for (int k = 1; k < SQ_STAGES; k++) begin
            sum_line_ff[k] <= sum_line_ff[k-1];
         end
         out_sq_ff <= sum_line_ff[SQ_STAGES-1];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_meta_ff.last;
   assign rsp_tdata  = {4'b0000, out_res_ff, out_sq_ff, out_disp_ff[2], out_disp_ff[1],
                        out_disp_ff[0], out_meta_ff.partner, out_meta_ff.who};

endmodule

`default_nettype wire

### sv/min_image_pair_distances.sv
// A move record passes through the store read, the queue, six math stages, eight
// root stages and the output register once the command is taken.
// Throughput: one pair record per cycle while the receiver is ready; the front
// takes no new command until its partner walk ends, paced by the single store read port.
// Reset is synchronous; positions read as the origin until written (per-entry
// valid flags, no clearing pass), registers return to their reset values.
// ----------------------------------------------------------------------------
// min_image_pair_distances
// Periodic-box pair distance engine: position store, partner walk and
// minimum-image math pipe with a pipelined square root.
// ----------------------------------------------------------------------------
`default_nettype none

module min_image_pair_distances (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [103:0]  req_tdata,  // particle, pos_x, pos_y, pos_z, zero pad
   input  wire logic          req_tuser,  // command
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [207:0]       rsp_tdata,  // moved, partner, disp_x, disp_y, disp_z,
                                          // dist_sq, dist_res, zero pad
   output logic               rsp_tlast,
   input  wire logic          csr_we,
   input  wire logic [2:0]    csr_addr,
   input  wire logic [31:0]   csr_wdata
);
   import mipd_pkg::*;

   logic [CNT_W-1:0]    active_ff;
   geom_type            geom_ff;
   vec_type             req_pos;
   logic                push_valid;
   pair_type            push_data;
   logic                pop;
   logic                head_valid;
   pair_type            head_data;
   logic [FIFO_CNT_W-1:0] fifo_cnt;

   assign req_pos = {req_tdata[101:70], req_tdata[69:38], req_tdata[37:6]};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= CNT_W'(32);
         geom_ff.box <= {3{31'd65536}};
         geom_ff.inv <= {3{32'd65536}};
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ACTIVE: active_ff      <= csr_wdata[CNT_W-1:0];
            CSR_BOX_X:  geom_ff.box[0] <= csr_wdata[30:0];
            CSR_BOX_Y:  geom_ff.box[1] <= csr_wdata[30:0];
            CSR_BOX_Z:  geom_ff.box[2] <= csr_wdata[30:0];
            CSR_INV_X:  geom_ff.inv[0] <= csr_wdata;
            CSR_INV_Y:  geom_ff.inv[1] <= csr_wdata;
            CSR_INV_Z:  geom_ff.inv[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   mipd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .active_count (active_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_command  (req_tuser),
      .req_particle (req_tdata[IDX_W-1:0]),
      .req_pos      (req_pos),
      .push_valid   (push_valid),
      .push_data    (push_data),
      .fifo_cnt     (fifo_cnt)
   );

   mipd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .count      (fifo_cnt)
   );

   mipd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom_ff),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for min_image_pair_distances. Moves and restores
// particles over the stream input and predicts every pair record with a
// local model of the position store and the minimum-image arithmetic.
// Records are compared field by field, in order. The box and particle count
// are reprogrammed between phases, including the extreme settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import mipd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [5:0]  moved;
      logic [5:0]  partner;
      logic [31:0] disp_x;
      logic [31:0] disp_y;
      logic [31:0] disp_z;
      logic [63:0] dist_sq;
      logic [31:0] dist_res;
      logic        last;
   } pair_rec_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [103:0]  req_tdata;
   logic          req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [207:0]  rsp_tdata;
   logic          rsp_tlast;
   logic          csr_we;
   logic [2:0]    csr_addr;
   logic [31:0]   csr_wdata;

   // local copy of the block state
   logic signed [31:0] pos_tbl [MAX_PART][3];
   logic signed [31:0] saved_pos [3];
   logic [5:0]         saved_idx;
   logic [6:0]         active_cnt;
   logic [30:0]        box_len [3];
   logic [31:0]        inv_len [3];

   pair_rec_type pending_pairs [$];
   int        error_count;
   bit        idle_on;

   min_image_pair_distances dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic signed [31:0] wrap_disp(longint d, int ax);
      longint ih, il, t, g;
      ih = longint'(inv_len[ax][31:16]);
      il = longint'(inv_len[ax][15:0]);
      t  = d * ih + ((d * il) >>> 16);
      g  = ((t + 32768) & 65535) - 32768;
      return 32'((longint'(box_len[ax]) * g) >>> 16);
   endfunction

   function automatic logic [31:0] floor_sqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[31:0];
   endfunction

   function automatic int live_count();
      return (active_cnt > MAX_PART) ? MAX_PART : int'(active_cnt);
   endfunction

   function automatic void queue_pairs(logic [5:0] who);
      int        n, lo, hi, k;
      pair_rec_type r;
      logic signed [31:0] dv [3];
      logic [64:0] acc;
      n = live_count();
      k = 0;
      if (who >= n) return;
      for (int p = 0; p < n; p++) begin
         if (p == who) continue;
         lo = (p < who) ? p : who;
         hi = (p < who) ? who : p;
         acc = 0;
         for (int a = 0; a < 3; a++) begin
            dv[a] = wrap_disp(longint'(pos_tbl[lo][a]) - longint'(pos_tbl[hi][a]), a);
            acc = acc + 65'(64'(longint'(dv[a]) * longint'(dv[a])));
            if (acc[64]) acc = {1'b0, {64{1'b1}}};
         end
         r.moved    = who;
         r.partner  = 6'(p);
         r.disp_x   = dv[0];
         r.disp_y   = dv[1];
         r.disp_z   = dv[2];
         r.dist_sq  = acc[63:0];
         r.dist_res = floor_sqrt(acc[63:0]);
         r.last     = 1'b0;
         pending_pairs.push_back(r);
         k++;
      end
      if (k > 0) pending_pairs[pending_pairs.size()-1].last = 1'b1;
   endfunction

   function automatic void apply_command(logic cmd, logic [5:0] who,
                                         logic [31:0] x, logic [31:0] y, logic [31:0] z);
      if (cmd == CMD_MOVE) begin
         if (who >= live_count()) return;
         for (int a = 0; a < 3; a++) saved_pos[a] = pos_tbl[who][a];
         pos_tbl[who][0] = x;
         pos_tbl[who][1] = y;
         pos_tbl[who][2] = z;
         saved_idx = who;
         queue_pairs(who);
      end else begin
         for (int a = 0; a < 3; a++) pos_tbl[saved_idx][a] = saved_pos[a];
         queue_pairs(saved_idx);
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // check each result transaction against the oldest expectation
   always @(posedge clock) begin
      pair_rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pairs.size() == 0) begin
            report_mismatch("unexpected record", rsp_tdata[63:0], 64'd0);
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_tdata[5:0] != want.moved)
               report_mismatch("moved", rsp_tdata[5:0], want.moved);
            if (rsp_tdata[11:6] != want.partner)
               report_mismatch("partner", rsp_tdata[11:6], want.partner);
            if (rsp_tdata[43:12] != want.disp_x)
               report_mismatch("disp_x", rsp_tdata[43:12], want.disp_x);
            if (rsp_tdata[75:44] != want.disp_y)
               report_mismatch("disp_y", rsp_tdata[75:44], want.disp_y);
            if (rsp_tdata[107:76] != want.disp_z)
               report_mismatch("disp_z", rsp_tdata[107:76], want.disp_z);
            if (rsp_tdata[171:108] != want.dist_sq)
               report_mismatch("dist_sq", rsp_tdata[171:108], want.dist_sq);
            if (rsp_tdata[203:172] != want.dist_res)
               report_mismatch("dist_res", rsp_tdata[203:172], want.dist_res);
            if (rsp_tlast != want.last)
               report_mismatch("last", rsp_tlast, want.last);
         end
      end
   end

   // receiver stalls in random bursts
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_item(logic cmd, logic [5:0] who,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, z, y, x, who};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_command(cmd, who, x, y, z);
   endtask

   // hold off until every record is back, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_ACTIVE: active_cnt = value[6:0];
         CSR_BOX_X:  box_len[0] = value[30:0];
         CSR_BOX_Y:  box_len[1] = value[30:0];
         CSR_BOX_Z:  box_len[2] = value[30:0];
         CSR_INV_X:  inv_len[0] = value;
         CSR_INV_Y:  inv_len[1] = value;
         CSR_INV_Z:  inv_len[2] = value;
         default: ;
      endcase
   endtask

   task automatic set_box(int ax, logic [30:0] len, logic [31:0] inv);
      write_reg(3'(CSR_BOX_X + ax), {1'b0, len});
      write_reg(3'(CSR_INV_X + ax), inv);
   endtask

   function automatic logic [31:0] recip(logic [30:0] len);
      logic [63:0] q;
      q = (64'd1 << 32) / len;
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic logic [31:0] rand_coord(bit wide);
      if (wide) return $urandom;
      return 32'($signed($urandom_range(0, 262143)) - 131072);
   endfunction

   task automatic random_items(int count, int restore_pct, int wide_pct);
      int n;
      for (int i = 0; i < count; i++) begin
         n = live_count();
         if ($urandom_range(0, 99) < restore_pct)
            send_item(CMD_RESTORE, 6'($urandom), $urandom, $urandom, $urandom);
         else if ($urandom_range(0, 19) == 0 || n == 0)
            send_item(CMD_MOVE, 6'($urandom), $urandom, $urandom, $urandom);
         else
            send_item(CMD_MOVE, 6'($urandom_range(0, n - 1)),
                      rand_coord($urandom_range(0, 99) < wide_pct),
                      rand_coord($urandom_range(0, 99) < wide_pct),
                      rand_coord($urandom_range(0, 99) < wide_pct));
      end
   endtask

   task automatic test_reset_state();
      // restore before any move reports particle 0 at the origin
      send_item(CMD_RESTORE, 6'd0, 32'd0, 32'd0, 32'd0);
      send_item(CMD_MOVE, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(CMD_MOVE, 6'd31, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000);
      send_item(CMD_MOVE, 6'd1, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_0000);
      send_item(CMD_RESTORE, 6'd5, 32'd0, 32'd0, 32'd0);
      send_item(CMD_RESTORE, 6'd5, 32'd0, 32'd0, 32'd0);
      // inactive particle moved: no store, no records
      send_item(CMD_MOVE, 6'd40, 32'h1234_5678, 32'd1, 32'd2);
      send_item(CMD_MOVE, 6'd63, 32'h1234_5678, 32'd1, 32'd2);
      send_item(CMD_RESTORE, 6'd0, 32'd0, 32'd0, 32'd0);
      drain();
   endtask

   task automatic test_count_edges();
      write_reg(CSR_ACTIVE, 32'd64);
      send_item(CMD_MOVE, 6'd63, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_4000);
      send_item(CMD_MOVE, 6'd32, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
      drain();
      // restore of a particle that has since become inactive
      write_reg(CSR_ACTIVE, 32'd4);
      send_item(CMD_RESTORE, 6'd0, 32'd0, 32'd0, 32'd0);
      send_item(CMD_MOVE, 6'd3, 32'h0000_C000, 32'h0000_4000, 32'h0001_8000);
      drain();
      write_reg(CSR_ACTIVE, 32'd127);
      send_item(CMD_MOVE, 6'd50, $urandom, $urandom, $urandom);
      drain();
      write_reg(CSR_ACTIVE, 32'd1);
      send_item(CMD_MOVE, 6'd0, $urandom, $urandom, $urandom);
      send_item(CMD_RESTORE, 6'd0, 32'd0, 32'd0, 32'd0);
      drain();
      write_reg(CSR_ACTIVE, 32'd0);
      send_item(CMD_MOVE, 6'd0, $urandom, $urandom, $urandom);
      drain();
      write_reg(CSR_ACTIVE, 32'd2);
      send_item(CMD_MOVE, 6'd1, 32'h0000_7FFF, 32'h0000_8000, 32'hFFFF_8000);
      send_item(CMD_RESTORE, 6'd0, 32'd0, 32'd0, 32'd0);
      drain();
   endtask

   task automatic test_box_extremes();
      write_reg(CSR_ACTIVE, 32'd8);
      set_box(0, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
      set_box(1, 31'd1, 32'hFFFF_FFFF);
      set_box(2, 31'h7FFF_FFFF, 32'd0);
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      random_items(10, 15, 80);
      drain();
      set_box(0, 31'd0, 32'd65536);
      set_box(1, 31'h7FFF_FFFF, 32'd1);
      set_box(2, 31'd1, 32'd0);
      random_items(8, 15, 80);
      drain();
   endtask

   task automatic test_random_boxes();
      logic [30:0] len;
      int counts [4] = '{6, 17, 33, 64};
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_ACTIVE, 32'(counts[$urandom_range(0, 3)]));
         for (int a = 0; a < 3; a++) begin
            len = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 8) << 16);
            if (len == 0) len = 31'd1;
            set_box(a, len, recip(len));
         end
         random_items(30, 15, 20);
         drain();
      end
   endtask

   task automatic test_tail_no_idle();
      idle_on = 1'b0;
      write_reg(CSR_ACTIVE, 32'd64);
      set_box(0, 31'd65536, 32'd65536);
      random_items(80, 20, 30);
      drain();
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_we      = 1'b0;
      csr_addr    = CSR_ACTIVE;
      csr_wdata   = '0;
      error_count = 0;
      idle_on     = 1'b1;
      active_cnt  = 7'd32;
      saved_idx   = '0;
      for (int a = 0; a < 3; a++) begin
         box_len[a]   = 31'd65536;
         inv_len[a]   = 32'd65536;
         saved_pos[a] = '0;
      end
      for (int i = 0; i < MAX_PART; i++)
         for (int a = 0; a < 3; a++) pos_tbl[i][a] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_count_edges();
      test_box_extremes();
      test_random_boxes();
      test_tail_no_idle();

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
